>>> rtl/core/okpm_pkg.sv
// ---------------------------------------------------------------------------
// okpm_pkg
// Shared types and constants for the order-key partition mapper.
// ---------------------------------------------------------------------------
package okpm_pkg;

    // request kinds on the input stream (tuser)
    typedef enum logic
    {
        CMD_MAP   = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    // configuration register indexes
    typedef enum logic
    {
        CFG_ROWS_PER_BUCKET = 1'b0,
        CFG_BUCKET_COUNT    = 1'b1
    } cfg_idx_t;

    localparam int KEY_W    = 63;
    localparam int ROW_W    = 61;
    localparam int DIV_W    = 32;
    localparam int COUNT_W  = 9;
    localparam int IDX_W    = 8;
    localparam int PART_W   = 16;
    localparam int QUOT_W   = COUNT_W;
    localparam int REM_W    = QUOT_W + DIV_W;
    localparam int S_DATA_W = 88;

    // input tdata field offsets
    localparam int KEY_LSB  = 0;
    localparam int NULL_BIT = KEY_LSB + KEY_W;
    localparam int IDX_LSB  = NULL_BIT + 1;
    localparam int PART_LSB = IDX_LSB + IDX_W;

    // payload carried through the divide stages
    typedef struct packed
    {
        logic                is_write;
        logic                zero_out;
        logic                ovf;
        logic                clamp;
        logic [REM_W-1:0]    rem;
        logic [QUOT_W-1:0]   quot;
        logic [IDX_W-1:0]    idx;
        logic [PART_W-1:0]   part;
    } pipe_t;

endpackage

>>> rtl/core/order_key_partition_mapper_top.sv
// ---------------------------------------------------------------------------
// order_key_partition_mapper_top
// Maps rows to partitions by dense row number, bucket divide and table lookup.
// ---------------------------------------------------------------------------
// Input stream s_*: tuser selects map (row) or table-write request. A map
// request yields one result on m_*; a table-write request yields none and
// loads one partition table entry in request order relative to lookups.
// Configuration requests on cfg_* set rows_per_bucket and bucket_count; they
// are always accepted and must only be issued while the pipeline is empty.
// Path from an accepted map request to m_tvalid: decode and multiply, range
// compare, 9 single-bit divide steps, table read.
// Throughput: one request per cycle while not stalled; the 9-stage restoring
// divider and the single table port each take one request per cycle.
// When m_tready is low with a result pending, the whole pipeline holds and
// s_tready drops; bubbles still advance while the output stage is empty.
// Reset clears all valid bits and sets rows_per_bucket and bucket_count to 1.
// The partition table is not cleared; entries must be written before use.
// ---------------------------------------------------------------------------
module order_key_partition_mapper_top
    import okpm_pkg::*;
#(
    parameter int TABLE_DEPTH    = 256,
    parameter int PARTITION_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // s_tdata: order_key[62:0], key_is_null[63], entry_index[71:64],
    //          entry_partition[87:72]
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: command[0]
    input  logic                s_tuser,
    // m_tdata: partition_id[PARTITION_BITS-1:0], overflow[PARTITION_BITS],
    //          zero fill above
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((PARTITION_BITS+8)/8)*8-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [DIV_W-1:0]    cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                 adv;
    logic [DIV_W-1:0]     div_reg;
    logic [COUNT_W-1:0]   last_reg;
    logic [COUNT_W-1:0]   cnt_eff;

    // stage 1
    logic                 s1_valid_reg;
    logic                 s1_write_reg;
    logic                 s1_null_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [REM_W-1:0]     s1_prod_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [PART_W-1:0]    s1_part_reg;
    logic [ROW_W-1:0]     dense;
    logic [KEY_W-1:0]     in_key;

    // stage 2 and divider
    logic                 s2_valid_reg;
    pipe_t                s2_reg;
    pipe_t                s2_next;
    logic                 stg_valid [QUOT_W+1];
    pipe_t                stg_pipe  [QUOT_W+1];

    // lookup stage
    pipe_t                lk;
    logic                 lk_valid;
    logic [COUNT_W-1:0]   bucket;
    logic                 idx_ok;
    logic [PARTITION_BITS-1:0] mem [TABLE_DEPTH];
    logic [PARTITION_BITS-1:0] rd_reg;
    logic                 s3_valid_reg;
    logic                 s3_write_reg;
    logic                 s3_zero_reg;
    logic                 s3_ovf_reg;

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // configuration, stored in effective form
    always_comb
    begin
        cnt_eff = (cfg_data[COUNT_W-1:0] == '0) ? COUNT_W'(1) : cfg_data[COUNT_W-1:0];
        if (32'(cnt_eff) > 32'(TABLE_DEPTH))
        begin
            cnt_eff = COUNT_W'(TABLE_DEPTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= DIV_W'(1);
            last_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS_PER_BUCKET:
                begin
                    div_reg <= (cfg_data == '0) ? DIV_W'(1) : cfg_data;
                end
                CFG_BUCKET_COUNT:
                begin
                    last_reg <= cnt_eff - COUNT_W'(1);
                end
                default:
                begin
                    div_reg <= div_reg;
                end
            endcase
        end
    end

    // stage 1: dense row number and clamp threshold
    assign in_key = s_tdata[KEY_LSB +: KEY_W];
    assign dense  = {in_key[KEY_W-1:5], in_key[2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_write_reg <= (cmd_t'(s_tuser) == CMD_WRITE);
            s1_null_reg  <= s_tdata[NULL_BIT];
            s1_row_reg   <= (dense == '0) ? '0 : dense - ROW_W'(1);
            s1_prod_reg  <= REM_W'(last_reg) * REM_W'(div_reg);
            s1_idx_reg   <= s_tdata[IDX_LSB +: IDX_W];
            s1_part_reg  <= s_tdata[PART_LSB +: PART_W];
        end
    end

    // stage 2: overflow and clamp decisions
    always_comb
    begin
        s2_next          = '0;
        s2_next.is_write = s1_write_reg;
        s2_next.ovf      = !s1_null_reg &&
                           ({2'b00, s1_row_reg} >= {div_reg, 31'd0});
        s2_next.zero_out = s1_null_reg || s2_next.ovf;
        s2_next.clamp    = s1_row_reg >= ROW_W'(s1_prod_reg);
        s2_next.rem      = s1_row_reg[REM_W-1:0];
        s2_next.idx      = s1_idx_reg;
        s2_next.part     = s1_part_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    assign stg_valid[0] = s2_valid_reg;
    assign stg_pipe[0]  = s2_reg;

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        okpm_div_stage #(
            .BIT (QUOT_W - 1 - k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .divisor   (div_reg),
            .in_valid  (stg_valid[k]),
            .in_pipe   (stg_pipe[k]),
            .out_valid (stg_valid[k+1]),
            .out_pipe  (stg_pipe[k+1])
        );
    end

    // table stage: writes and lookups in request order
    assign lk_valid = stg_valid[QUOT_W];
    assign lk       = stg_pipe[QUOT_W];
    assign bucket   = lk.clamp ? last_reg : lk.quot;
    assign idx_ok   = {24'd0, lk.idx} < 32'(TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (adv && lk_valid)
        begin
            if (lk.is_write)
            begin
                if (idx_ok)
                begin
                    mem[ADDR_W'(lk.idx)] <= PARTITION_BITS'(lk.part);
                end
            end
            else
            begin
                rd_reg <= mem[ADDR_W'(bucket)];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= lk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_write_reg <= lk.is_write;
            s3_zero_reg  <= lk.zero_out;
            s3_ovf_reg   <= lk.ovf;
        end
    end

    assign m_tvalid = s3_valid_reg && !s3_write_reg;

    always_comb
    begin
        m_tdata                   = '0;
        m_tdata[PARTITION_BITS-1:0] = s3_zero_reg ? '0 : rd_reg;
        m_tdata[PARTITION_BITS]     = s3_ovf_reg;
    end

endmodule

>>> rtl/core/okpm_div_stage.sv
// ---------------------------------------------------------------------------
// okpm_div_stage
// One restoring-divide step: resolves quotient bit BIT and registers it.
// ---------------------------------------------------------------------------
module okpm_div_stage
    import okpm_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [DIV_W-1:0] divisor,
    input  logic             in_valid,
    input  pipe_t            in_pipe,
    output logic             out_valid,
    output pipe_t            out_pipe
);

    logic              valid_reg;
    pipe_t             pipe_reg;
    pipe_t             pipe_next;
    logic [REM_W-1:0]  trial;
    logic              fits;

    assign trial = REM_W'(divisor) << BIT;
    assign fits  = in_pipe.rem >= trial;

    always_comb
    begin
        pipe_next = in_pipe;
        if (fits)
        begin
            pipe_next.rem       = in_pipe.rem - trial;
            pipe_next.quot[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg <= pipe_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

>>> rtl/core/okpm_checker.sv
// ---------------------------------------------------------------------------
// okpm_checker
// Port-level checks for the partition mapper, bound to the top level.
// ---------------------------------------------------------------------------
module okpm_checker
    import okpm_pkg::*;
#(
    parameter int PARTITION_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [((PARTITION_BITS+8)/8)*8-1:0] m_tdata,
    input  logic                cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // overflow forces partition 0
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[PARTITION_BITS] |-> m_tdata[PARTITION_BITS-1:0] == '0)
        else $error("overflow with nonzero partition");

    // an empty output stage never back-pressures the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // input and configuration ready stay high while a result is taken
    a_ready_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> s_tready && cfg_ready)
        else $error("input stalled while result is taken");

endmodule

bind order_key_partition_mapper_top okpm_checker #(
    .PARTITION_BITS (PARTITION_BITS)
) u_okpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
